// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CSVT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CSVT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CSVT_ASSERT(label, cond, msg)
`define CSVT_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/csvt_pkg.sv =====
// Types and constants shared by the CSV record tokenizer modules.
package csvt_pkg;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int unsigned CR_CNT_W   = 4;
  localparam int unsigned CR_CNT_MAX = 15;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CR_CNT_W-1:0] cr_cnt;
    logic                lost;
    logic                has_item;
    kind_t               kind;
    logic [7:0]          data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/csvt_fifo.sv =====
// Short command queue between the classifying front end and the result back end.
module csvt_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  csvt_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output csvt_pkg::cmd_t      head_cmd,
  output csvt_pkg::fifo_stat_t stat
);

  csvt_pkg::cmd_t                 mem_r [csvt_pkg::FIFO_DEPTH];
  logic [csvt_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [csvt_pkg::FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [csvt_pkg::FIFO_AW:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? csvt_pkg::FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? csvt_pkg::FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = (csvt_pkg::FIFO_AW+1)'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = (csvt_pkg::FIFO_AW+1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd      = mem_r[rd_ptr_r];
  assign stat.full     = (count_r == (csvt_pkg::FIFO_AW+1)'(csvt_pkg::FIFO_DEPTH));
  assign stat.nonempty = (count_r != '0);

endmodule

// ===== hw/rtl/csvt_front.sv =====
// Front end: accepts text bytes, tracks quoting and held carriage returns, queues commands.
module csvt_front #(
  parameter int unsigned MAX_HELD_CR = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_text_end,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  csvt_pkg::fifo_stat_t fifo_stat,
  output logic                 push,
  output csvt_pkg::cmd_t       push_cmd
);

  localparam logic [csvt_pkg::CR_CNT_W-1:0] HOLD_CAP =
    (MAX_HELD_CR > csvt_pkg::CR_CNT_MAX) ? csvt_pkg::CR_CNT_W'(csvt_pkg::CR_CNT_MAX)
                                         : csvt_pkg::CR_CNT_W'(MAX_HELD_CR);

  logic                          skip_r;
  logic                          quoted_r, quoted_nxt;
  logic                          pending_r, pending_nxt;
  logic [csvt_pkg::CR_CNT_W-1:0] held_r, held_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          nonempty_r, nonempty_nxt;
  logic                          first_r, first_nxt;
  logic                          quoted_eff;
  logic                          muted;
  logic                          accept;
  csvt_pkg::cmd_t                cmd;

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;
  assign muted    = skip_r && first_r;

  always_comb begin
    quoted_nxt   = quoted_r;
    pending_nxt  = pending_r;
    held_nxt     = held_r;
    ovf_nxt      = ovf_r;
    nonempty_nxt = nonempty_r;
    first_nxt    = first_r;
    quoted_eff   = quoted_r && !pending_r;
    cmd          = '0;
    cmd.kind     = csvt_pkg::KIND_DATA;
    if (in_text_end) begin
      cmd.has_item = nonempty_r;
      cmd.kind     = csvt_pkg::KIND_RECORD_END;
      quoted_nxt   = 1'b0;
      pending_nxt  = 1'b0;
      held_nxt     = '0;
      ovf_nxt      = 1'b0;
      nonempty_nxt = 1'b0;
      first_nxt    = 1'b1;
    end else if (pending_r && in_text_byte == csvt_pkg::CHAR_QUOTE) begin
      pending_nxt  = 1'b0;
      nonempty_nxt = 1'b1;
      cmd.has_item = 1'b1;
      cmd.data     = csvt_pkg::CHAR_QUOTE;
    end else begin
      pending_nxt = 1'b0;
      quoted_nxt  = quoted_eff;
      if (in_text_byte == csvt_pkg::CHAR_CR) begin
        if (held_r < HOLD_CAP) begin
          held_nxt = csvt_pkg::CR_CNT_W'(held_r + 1'b1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (in_text_byte == csvt_pkg::CHAR_LF && !quoted_eff) begin
        cmd.has_item = nonempty_r;
        cmd.kind     = csvt_pkg::KIND_RECORD_END;
        quoted_nxt   = 1'b0;
        held_nxt     = '0;
        ovf_nxt      = 1'b0;
        nonempty_nxt = 1'b0;
        first_nxt    = 1'b0;
      end else begin
        cmd.cr_cnt   = held_r;
        cmd.lost     = ovf_r;
        held_nxt     = '0;
        ovf_nxt      = 1'b0;
        nonempty_nxt = 1'b1;
        if (in_text_byte == csvt_pkg::CHAR_QUOTE) begin
          if (quoted_eff) begin
            pending_nxt = 1'b1;
          end else begin
            quoted_nxt = 1'b1;
          end
        end else if (in_text_byte == csvt_pkg::CHAR_COMMA && !quoted_eff) begin
          cmd.has_item = 1'b1;
          cmd.kind     = csvt_pkg::KIND_FIELD_END;
        end else begin
          cmd.has_item = 1'b1;
          cmd.data     = in_text_byte;
        end
      end
    end
  end

  assign push     = accept && !muted && (cmd.cr_cnt != '0 || cmd.has_item);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r     <= 1'b1;
      quoted_r   <= 1'b0;
      pending_r  <= 1'b0;
      held_r     <= '0;
      ovf_r      <= 1'b0;
      nonempty_r <= 1'b0;
      first_r    <= 1'b1;
    end else begin
      if (cfg_we) begin
        skip_r <= cfg_wdata;
      end
      if (accept) begin
        quoted_r   <= quoted_nxt;
        pending_r  <= pending_nxt;
        held_r     <= held_nxt;
        ovf_r      <= ovf_nxt;
        nonempty_r <= nonempty_nxt;
        first_r    <= first_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/csvt_back.sv =====
// Back end: expands each queued command into released carriage returns and its final result.
module csvt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csvt_pkg::fifo_stat_t fifo_stat,
  input  csvt_pkg::cmd_t       head_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_item_kind,
  output logic [7:0]           out_field_byte,
  output logic                 out_run_last,
  output logic                 out_cr_lost
);

  logic                          valid_r, valid_nxt;
  logic [1:0]                    kind_r;
  logic [7:0]                    byte_r;
  logic                          last_r;
  logic                          lost_r;
  logic [csvt_pkg::CR_CNT_W-1:0] done_r, done_nxt;
  logic                          load;
  logic                          emit_cr;
  logic                          res_last;
  logic [1:0]                    res_kind;
  logic [7:0]                    res_byte;

  assign load    = fifo_stat.nonempty && (!valid_r || out_ready);
  assign emit_cr = (done_r != head_cmd.cr_cnt);

  always_comb begin
    if (emit_cr) begin
      res_kind = csvt_pkg::KIND_DATA;
      res_byte = csvt_pkg::CHAR_CR;
      res_last = (csvt_pkg::CR_CNT_W'(done_r + 1'b1) == head_cmd.cr_cnt) && !head_cmd.has_item;
    end else begin
      res_kind = head_cmd.kind;
      res_byte = (head_cmd.kind == csvt_pkg::KIND_DATA) ? head_cmd.data : 8'h00;
      res_last = 1'b1;
    end
    pop       = load && res_last;
    done_nxt  = done_r;
    if (load) begin
      done_nxt = res_last ? '0 : csvt_pkg::CR_CNT_W'(done_r + 1'b1);
    end
    valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res_kind;
      byte_r <= res_byte;
      last_r <= res_last;
      lost_r <= head_cmd.lost;
    end
  end

  assign out_valid      = valid_r;
  assign out_item_kind  = kind_r;
  assign out_field_byte = byte_r;
  assign out_run_last   = last_r;
  assign out_cr_lost    = lost_r;

endmodule

// ===== hw/rtl/csv_record_tokenizer_unit.sv =====
// Top level of the CSV record tokenizer: front end, command queue, back end and checks.
//
// The input channel (in_valid/in_ready) takes one text byte per request, with
// in_text_end marking the end of the text. The output channel (out_valid/out_ready)
// gives one result per request: a data byte, an end of field or an end of record,
// with out_run_last on the last result caused by an input request.
// cfg_we writes cfg_wdata into skip_first_record; while it is 1 the header record
// gives no results.
// An accepted input passes the command queue and the output register before its
// first result is offered. Throughput is one input per cycle while each input gives
// at most one result and out_ready stays high; an input that releases held carriage
// returns gives a burst of results, which the four-entry command queue absorbs before
// in_ready drops. Reset clears quoting and held carriage returns, sets
// skip_first_record to 1 and empties the queue. When the receiver stalls, the current
// result holds in the output register, the queue fills, and then in_ready goes low.
`include "assert_macros.svh"

module csv_record_tokenizer_unit #(
  parameter int unsigned MAX_HELD_CR = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_field_byte,
  output logic       out_run_last,
  output logic       out_cr_lost,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  csvt_pkg::fifo_stat_t fifo_stat;
  csvt_pkg::cmd_t       push_cmd;
  csvt_pkg::cmd_t       head_cmd;
  logic                 push;
  logic                 pop;
  logic                 kind_ok;
  logic                 is_marker;

  csvt_front #(
    .MAX_HELD_CR(MAX_HELD_CR)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_text_end  (in_text_end),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fifo_stat    (fifo_stat),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  csvt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  csvt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_stat      (fifo_stat),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item_kind  (out_item_kind),
    .out_field_byte (out_field_byte),
    .out_run_last   (out_run_last),
    .out_cr_lost    (out_cr_lost)
  );

  assign kind_ok   = (out_item_kind == csvt_pkg::KIND_DATA) ||
                     (out_item_kind == csvt_pkg::KIND_FIELD_END) ||
                     (out_item_kind == csvt_pkg::KIND_RECORD_END);
  assign is_marker = out_valid && (out_item_kind != csvt_pkg::KIND_DATA);

  `CSVT_ASSERT_IMP(a_no_push_full, push, !fifo_stat.full, "push into full queue")
  `CSVT_ASSERT_IMP(a_no_pop_empty, pop, fifo_stat.nonempty, "pop from empty queue")
  `CSVT_ASSERT_IMP(a_kind_legal, out_valid, kind_ok, "illegal result kind")
  `CSVT_ASSERT_IMP(a_marker_zero, is_marker, out_field_byte == 8'h00, "marker carries a byte")

endmodule
